// ===== src/smf_pkg.sv =====
// Shared types and constants for the three-axis sliding median filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package smf_pkg;

  // Window length per axis and sample width.
  localparam int WINDOW_LEN   = 5;
  localparam int SAMPLE_WIDTH = 32;

  // Each window element carries its age in samples; the oldest has WINDOW_LEN-1.
  localparam int AGE_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int MEDIAN_IDX = WINDOW_LEN / 2;

  typedef logic [AGE_W-1:0] age_t;

  localparam age_t AGE_OLDEST = age_t'(WINDOW_LEN - 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // One request: a sample for each axis.
  typedef struct packed {
    sample_t sample_x;
    sample_t sample_y;
    sample_t sample_z;
  } smf_req_t;

  // One result: the median of each axis window.
  typedef struct packed {
    sample_t median_x;
    sample_t median_y;
    sample_t median_z;
  } smf_rsp_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    sample_t value;     // Stored sample.
    age_t    age;       // Age of the stored sample.
    logic    new_lt;    // The incoming sample orders before the stored one.
    logic    del_seen;  // The oldest element sits at or left of this cell.
  } smf_link_t;

endpackage

`default_nettype wire

// ===== src/smf_cell.sv =====
// One cell of the sorted window: holds a sample and its age.
// Depends on smf_pkg; instantiated in a row by smf_axis.
`default_nettype none

module smf_cell import smf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      shift_i,
  input  wire sample_t   sample_i,
  input  wire age_t      init_age_i,
  input  wire smf_link_t left_i,
  input  wire smf_link_t right_i,
  output smf_link_t      link_o
);

  sample_t value_q, value_d;
  age_t    age_q, age_d;
  logic    new_lt;
  logic    is_oldest;
  logic    del_here_or_left;
  logic    prev_lt;
  sample_t prev_value;
  age_t    prev_age;

  // Local compare and deletion flags.
  assign new_lt           = sample_i < value_q;
  assign is_oldest        = (age_q == AGE_OLDEST);
  assign del_here_or_left = left_i.del_seen | is_oldest;

  // Element that sits just left of this place once the oldest is removed.
  always_comb begin
    if (left_i.del_seen) begin
      prev_lt    = new_lt;
      prev_value = value_q;
      prev_age   = age_q;
    end else begin
      prev_lt    = left_i.new_lt;
      prev_value = left_i.value;
      prev_age   = left_i.age;
    end
  end

  // Remove the oldest element and insert the new sample, keeping the row sorted.
  always_comb begin
    value_d = value_q;
    age_d   = age_q;
    if (del_here_or_left) begin
      if (prev_lt) begin
        value_d = prev_value;
        age_d   = prev_age + age_t'(1);
      end else if (right_i.new_lt) begin
        value_d = sample_i;
        age_d   = '0;
      end else begin
        value_d = right_i.value;
        age_d   = right_i.age + age_t'(1);
      end
    end else begin
      if (left_i.new_lt) begin
        value_d = left_i.value;
        age_d   = left_i.age + age_t'(1);
      end else if (new_lt) begin
        value_d = sample_i;
        age_d   = '0;
      end else begin
        value_d = value_q;
        age_d   = age_q + age_t'(1);
      end
    end
  end

  // Window starts as zeros with distinct ages so one element leaves per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      age_q   <= init_age_i;
    end else if (shift_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign link_o.value    = value_q;
  assign link_o.age      = age_q;
  assign link_o.new_lt   = new_lt;
  assign link_o.del_seen = del_here_or_left;

endmodule

`default_nettype wire

// ===== src/smf_axis.sv =====
// Sorted window of one axis: a row of smf_cell instances, ascending order.
// Depends on smf_pkg and smf_cell.
`default_nettype none

module smf_axis import smf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire sample_t sample_i,
  output sample_t      median_o
);

  smf_link_t links     [WINDOW_LEN];
  smf_link_t left_link [WINDOW_LEN];
  smf_link_t right_link[WINDOW_LEN];

  // Row of cells; the ends see fixed boundary links.
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign left_link[i] = '{value: '0, age: '0, new_lt: 1'b0, del_seen: 1'b0};
    end else begin : g_left_inner
      assign left_link[i] = links[i-1];
    end
    if (i == WINDOW_LEN - 1) begin : g_right_end
      assign right_link[i] = '{value: '0, age: '0, new_lt: 1'b1, del_seen: 1'b0};
    end else begin : g_right_inner
      assign right_link[i] = links[i+1];
    end

    smf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift_i),
      .sample_i   (sample_i),
      .init_age_i (age_t'(i)),
      .left_i     (left_link[i]),
      .right_i    (right_link[i]),
      .link_o     (links[i])
    );
  end

  assign median_o = links[MEDIAN_IDX].value;

  // Checking aids: one oldest element, ascending order.
  logic [WINDOW_LEN-1:0] oldest_vec;
  logic                  sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      oldest_vec[k] = (links[k].age == AGE_OLDEST);
    end
    for (int k = 0; k + 1 < WINDOW_LEN; k++) begin
      if (links[k].value > links[k+1].value) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // Exactly one element is the oldest at all times.
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest_vec))
    else $error("smf_axis: oldest element is not unique");

  // The row stays in ascending order.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_ok)
    else $error("smf_axis: window row out of order");

  // Without a shift the median holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shift_i |=> $stable(median_o))
    else $error("smf_axis: median changed without a shift");

endmodule

`default_nettype wire

// ===== src/sliding_median_filter_three_axis.sv =====
// Top level of the three-axis sliding median filter.
// Depends on smf_pkg and smf_axis.
`default_nettype none

// Each request carries one signed Q16.16 sample per axis. Every axis keeps a
// window of its last WINDOW_LEN samples, cleared to zero at reset, as a sorted
// row of cells; each request removes the oldest entry and inserts the new one
// together, and the result is the element at sorted index
// WINDOW_LEN/2 of each axis (the upper median for an even length). A request
// is taken every cycle while the result side does not stall; its result is
// valid in the cycle after acceptance. The cell row itself is the result
// register, so while a result is stalled the input is stalled too.
module sliding_median_filter_three_axis import smf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire smf_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output smf_rsp_t      out_rsp_o
);

  logic out_valid_q, out_valid_d;
  logic accept;

  // Handshake: a new request may replace a result only once it is taken.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // One sorted window per axis.
  smf_axis u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i (in_req_i.sample_x),
    .median_o (out_rsp_o.median_x)
  );

  smf_axis u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i (in_req_i.sample_y),
    .median_o (out_rsp_o.median_y)
  );

  smf_axis u_axis_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i (in_req_i.sample_z),
    .median_o (out_rsp_o.median_z)
  );

  assign out_valid_o = out_valid_q;

  // An accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("top: accepted request produced no result");

  // A stalled result is neither lost nor overwritten.
  a_stalled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("top: stalled result changed");

  // A result without a preceding request is invented.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept && !(out_valid_o && out_stall_i)) |=> !out_valid_o)
    else $error("top: result valid without a request");

endmodule

`default_nettype wire

// ===== tb/sv/sliding_median_filter_three_axis_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the three-axis sliding median filter: random and directed requests,
// predicted medians checked against every result. Depends on smf_pkg and the block.
module sliding_median_filter_three_axis_tb;
  import smf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_N    = 1530;
  localparam int unsigned HOLD_AT     = 800;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned DRAIN_WAIT  = 4;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t S_ONE = sample_t'(32'h0001_0000);

  typedef struct {
    smf_req_t    req;
    int unsigned gap;
  } pending_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  smf_req_t in_req_i    = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  smf_rsp_t out_rsp_o;

  pending_t    pend_q[$];
  smf_rsp_t    median_q[$];
  sample_t     win[3][WINDOW_LEN];
  logic        tx_taken    = 1'b0;
  logic        rx_taken    = 1'b0;
  logic        gap_armed   = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned rx_wait     = 0;
  int unsigned req_count   = 0;
  int unsigned rsp_count   = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  sliding_median_filter_three_axis uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Median of one axis window by insertion sort in signed order.
  function automatic sample_t axis_median(input int axis);
    sample_t sorted_v[WINDOW_LEN];
    sample_t v;
    int      j;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      v = win[axis][i];
      j = i;
      while (j > 0 && v < sorted_v[j-1]) begin
        sorted_v[j] = sorted_v[j-1];
        j--;
      end
      sorted_v[j] = v;
    end
    return sorted_v[MEDIAN_IDX];
  endfunction

  // Shift a request into the three windows and return the expected medians.
  function automatic smf_rsp_t shift_and_median(input smf_req_t req);
    smf_rsp_t rsp;
    for (int a = 0; a < 3; a++) begin
      for (int i = WINDOW_LEN - 1; i > 0; i--) begin
        win[a][i] = win[a][i-1];
      end
    end
    win[0][0] = req.sample_x;
    win[1][0] = req.sample_y;
    win[2][0] = req.sample_z;
    rsp.median_x = axis_median(0);
    rsp.median_y = axis_median(1);
    rsp.median_z = axis_median(2);
    return rsp;
  endfunction

  // Idle cycles for one item; some stretches of the run have no idling at all.
  function automatic int unsigned pick_wait(input int unsigned n);
    if ((n >= 300 && n < 450) || (n >= 1000 && n < 1120)) begin
      return 0;
    end
    if ($urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Random sample, weighted toward extremes, zero and small clustered values.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return sample_t'($signed($urandom_range(0, 8)) - 4);
      4: return sample_t'($urandom_range(0, 3)) * S_ONE;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic add_sample(input sample_t x, input sample_t y, input sample_t z);
    pending_t p;
    p.req.sample_x = x;
    p.req.sample_y = y;
    p.req.sample_z = z;
    p.gap = pick_wait(pend_q.size());
    pend_q.push_back(p);
  endtask

  function automatic void check_field(input string name, input sample_t exp_v,
                                      input sample_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Sender: offers queued requests after each one's idle gap, holds while stalled.
  always @(negedge clk_i) begin
    logic     offer;
    pending_t cur;
    offer = in_valid_i && !tx_taken;
    if (rst_ni && !offer) begin
      if (!gap_armed && pend_q.size() != 0) begin
        gap_left  = pend_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed) begin
        if (gap_left == 0) begin
          cur = pend_q.pop_front();
          in_req_i <= cur.req;
          offer     = 1'b1;
          gap_armed = 1'b0;
        end else begin
          gap_left--;
        end
      end
    end
    in_valid_i <= offer;
  end

  // Receiver: stalls each result for a drawn number of cycles, plus the long hold.
  always @(negedge clk_i) begin
    if (rx_taken) begin
      rx_wait = pick_wait(rsp_count);
    end
    out_stall_i <= (hold_left != 0) || (out_valid_o && rx_wait != 0);
    if (out_valid_o && rx_wait != 0) begin
      rx_wait--;
    end
  end

  // Long receiver hold-off partway through, so the block backs up into its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_count >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each accepted result, then predicts each accepted request.
  always @(posedge clk_i) begin
    smf_rsp_t exp_rsp;
    if (rst_ni) begin
      tx_taken <= in_valid_i && !in_stall_o;
      rx_taken <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) begin
        rsp_count <= rsp_count + 1;
        if (median_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_rsp_o);
          error_count++;
        end else begin
          exp_rsp = median_q.pop_front();
          check_field("median_x", exp_rsp.median_x, out_rsp_o.median_x);
          check_field("median_y", exp_rsp.median_y, out_rsp_o.median_y);
          check_field("median_z", exp_rsp.median_z, out_rsp_o.median_z);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        req_count <= req_count + 1;
        median_q.push_back(shift_and_median(in_req_i));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_median_filter_three_axis: mismatch");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[a][i] = '0;
      end
    end

    // Directed requests: reset zeros still in the window, extremes, ties.
    add_sample(S_MAX, S_MIN, 1);
    add_sample(S_MIN, S_MAX, -1);
    add_sample(1, -1, 0);
    add_sample(-1, 1, S_MAX);
    add_sample(0, 0, S_MIN);
    for (int i = 0; i < 5; i++) begin
      add_sample(S_MAX, S_MAX, S_MAX);
    end
    for (int i = 0; i < 3; i++) begin
      add_sample(S_MIN, S_MIN, S_MIN);
    end
    add_sample(S_ONE, -S_ONE, sample_t'(32'h7FFF_0000));
    add_sample(-S_ONE, sample_t'(32'h8000_0001), S_ONE);
    add_sample(sample_t'(32'h0000_8000), S_ONE, -S_ONE);
    add_sample(S_ONE, S_ONE, sample_t'(32'h0000_8000));
    add_sample(sample_t'(32'h8000_0001), sample_t'(32'h7FFF_0000), S_MIN);
    add_sample(S_MAX, 0, S_MAX);
    add_sample(S_MIN, 0, S_MIN);
    add_sample(0, S_MAX, 0);
    add_sample(0, S_MIN, 0);

    // Random requests.
    for (int n = 0; n < RANDOM_N; n++) begin
      add_sample(rand_sample(), rand_sample(), rand_sample());
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all requests to go in and every result to come back.
    while (pend_q.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (median_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("sliding_median_filter_three_axis: match");
    end else begin
      $display("sliding_median_filter_three_axis: mismatch");
    end
    $finish;
  end

endmodule
